[design/dltq_pkg.sv]
// Shared types, sizes and codes for the delta-list timer queue.
// No dependencies; used by dltq_ctrl, dltq_datapath and delta_list_timer_queue.
package dltq_pkg;

    localparam int unsigned TIMER_SLOTS   = 16;
    localparam int unsigned DELAY_BITS    = 32;
    localparam int unsigned ID_BITS       = 4;
    localparam int unsigned IN_DELAY_BITS = 32;
    localparam int unsigned OPCODE_BITS   = 2;
    localparam int unsigned STATUS_BITS   = 2;
    localparam int unsigned NUM_IDS       = 2 ** ID_BITS;
    localparam int unsigned SLOT_BITS     = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int unsigned COUNT_BITS    = $clog2(TIMER_SLOTS + 1);
    localparam int unsigned WIDE_BITS     =
        (DELAY_BITS > IN_DELAY_BITS) ? DELAY_BITS : IN_DELAY_BITS;

    typedef logic [ID_BITS-1:0]       id_t;
    typedef logic [DELAY_BITS-1:0]    delta_t;
    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [SLOT_BITS-1:0]     step_t;
    typedef logic [IN_DELAY_BITS-1:0] in_delay_t;

    localparam delta_t DELTA_MAX = '1;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_DUP    = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ACK    = 1'b0,
        KIND_EXPIRY = 1'b1
    } kind_t;

    typedef struct packed {
        id_t    id;
        delta_t delta;
    } slot_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    add_step;
        logic    rem_step;
        logic    tick_dec;
        logic    tick_emit;
        logic    ack_emit;
        status_t ack_status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic full;
        logic in_present;
        logic head_expired;
        logic pass_last;
        logic out_free;
    } dp_stat_t;

    // saturate to the delta width, zero delay counts as one tick
    function automatic delta_t clamp_delay(input in_delay_t d);
        logic [WIDE_BITS-1:0] d_wide;
        delta_t               r;
        d_wide = WIDE_BITS'(d);
        if (d_wide > WIDE_BITS'(DELTA_MAX)) begin
            r = DELTA_MAX;
        end else begin
            r = delta_t'(d_wide);
        end
        if (r == '0) begin
            r = delta_t'(1);
        end
        return r;
    endfunction

endpackage

[design/dltq_ctrl.sv]
// Sequencer for the timer queue: decodes each item and steps the datapath.
// Depends on dltq_pkg.
module dltq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [dltq_pkg::OPCODE_BITS-1:0] s_opcode,
    input  dltq_pkg::dp_stat_t  st,
    output dltq_pkg::dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_PASS,
        S_REM_PASS,
        S_ACK,
        S_TICK_DEC,
        S_TICK_CHK
    } state_t;

    state_t                state_reg, state_next;
    dltq_pkg::status_t     ack_status_reg, ack_status_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        ack_status_next = ack_status_reg;
        cmd             = '0;
        cmd.ack_status  = ack_status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_opcode)
                        dltq_pkg::OP_TICK: begin
                            if (!st.count_zero) begin
                                state_next = S_TICK_DEC;
                            end
                        end
                        dltq_pkg::OP_ADD: begin
                            if (st.in_present) begin
                                ack_status_next = dltq_pkg::ST_DUP;
                                state_next      = S_ACK;
                            end else if (st.full) begin
                                ack_status_next = dltq_pkg::ST_FULL;
                                state_next      = S_ACK;
                            end else begin
                                state_next = S_ADD_PASS;
                            end
                        end
                        dltq_pkg::OP_REMOVE: begin
                            if (!st.in_present) begin
                                ack_status_next = dltq_pkg::ST_ABSENT;
                                state_next      = S_ACK;
                            end else begin
                                state_next = S_REM_PASS;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_PASS: begin
                cmd.add_step = 1'b1;
                if (st.pass_last) begin
                    ack_status_next = dltq_pkg::ST_OK;
                    state_next      = S_ACK;
                end
            end
            S_REM_PASS: begin
                cmd.rem_step = 1'b1;
                if (st.pass_last) begin
                    ack_status_next = dltq_pkg::ST_OK;
                    state_next      = S_ACK;
                end
            end
            S_ACK: begin
                if (st.out_free) begin
                    cmd.ack_emit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_TICK_DEC: begin
                cmd.tick_dec = 1'b1;
                state_next   = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                // drain every head entry that has reached zero
                if (!st.head_expired) begin
                    state_next = S_IDLE;
                end else if (st.out_free) begin
                    cmd.tick_emit = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ack_status_reg <= ack_status_next;
    end

`ifndef NO_ASSERTIONS
    // the head can only be at zero while a tick is still draining it
    a_idle_head_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !st.head_expired)
        else $error("head entry expired outside a tick");
`endif

endmodule

[design/dltq_datapath.sv]
// Timer list datapath: a rotating ring of slots, occupancy bitmap and result register.
// Depends on dltq_pkg.
module dltq_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dltq_pkg::id_t                     s_timer_id,
    input  dltq_pkg::in_delay_t               s_delay_ticks,
    input  dltq_pkg::dp_cmd_t                 cmd,
    output dltq_pkg::dp_stat_t                st,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output dltq_pkg::id_t                     m_timer_id_res,
    output logic [dltq_pkg::STATUS_BITS-1:0]  m_status,
    output logic                              m_last
);

    localparam int unsigned N = dltq_pkg::TIMER_SLOTS;
    localparam int unsigned DB = dltq_pkg::DELAY_BITS;

    // slot 0 is the list head; every rotation pops slot 0 and pushes at the tail
    dltq_pkg::slot_t  slot_reg  [N];
    dltq_pkg::slot_t  slot_next [N];
    dltq_pkg::count_t count_reg, count_next;
    logic [dltq_pkg::NUM_IDS-1:0] present_reg, present_next;
    dltq_pkg::step_t  step_reg, step_next;
    logic             flag_reg, flag_next;
    dltq_pkg::id_t    op_id_reg, op_id_next;
    dltq_pkg::delta_t rem_reg, rem_next;
    dltq_pkg::slot_t  carry_reg, carry_next;

    logic                             m_valid_reg, m_valid_next;
    logic                             m_kind_reg, m_kind_next;
    dltq_pkg::id_t                    m_id_reg, m_id_next;
    logic [dltq_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic                             m_last_reg, m_last_next;

    dltq_pkg::slot_t  head;
    dltq_pkg::slot_t  second;
    dltq_pkg::slot_t  push;
    logic             shift;
    logic             head_valid;
    logic [DB:0]      sub_wide;
    logic             rem_ge;
    logic             pass_last;

    assign head       = slot_reg[0];
    assign second     = slot_reg[1];
    assign head_valid = dltq_pkg::count_t'(step_reg) < count_reg;
    assign sub_wide   = {1'b0, rem_reg} - {1'b0, head.delta};
    assign rem_ge     = !sub_wide[DB];
    assign pass_last  = (step_reg == dltq_pkg::step_t'(N - 1));

    assign st.count_zero   = (count_reg == '0);
    assign st.full         = (count_reg == dltq_pkg::count_t'(N));
    assign st.in_present   = present_reg[s_timer_id];
    assign st.head_expired = (count_reg != '0) && (head.delta == '0);
    assign st.pass_last    = pass_last;
    assign st.out_free     = !m_valid_reg || m_ready;

    always_comb begin
        slot_next     = slot_reg;
        count_next    = count_reg;
        present_next  = present_reg;
        step_next     = step_reg;
        flag_next     = flag_reg;
        op_id_next    = op_id_reg;
        rem_next      = rem_reg;
        carry_next    = carry_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_id_next     = m_id_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        push          = head;
        shift         = 1'b0;

        if (cmd.load) begin
            op_id_next = s_timer_id;
            rem_next   = dltq_pkg::clamp_delay(s_delay_ticks);
            flag_next  = 1'b0;
            step_next  = '0;
        end

        // add: copy entries while the remaining delay covers them, then place the
        // new timer and run the rest one slot late through the carry register
        if (cmd.add_step) begin
            shift     = 1'b1;
            step_next = step_reg + 1'b1;
            if (!flag_reg) begin
                if (head_valid && rem_ge) begin
                    push     = head;
                    rem_next = sub_wide[DB-1:0];
                end else begin
                    push.id          = op_id_reg;
                    push.delta       = rem_reg;
                    flag_next        = 1'b1;
                    carry_next.id    = head.id;
                    carry_next.delta = head.delta - rem_reg;
                end
            end else begin
                push       = carry_reg;
                carry_next = head;
            end
            if (pass_last) begin
                count_next              = count_reg + 1'b1;
                present_next[op_id_reg] = 1'b1;
            end
        end

        // remove: from the target onwards push the next slot, one ahead
        if (cmd.rem_step) begin
            shift     = 1'b1;
            step_next = step_reg + 1'b1;
            if (!flag_reg) begin
                if (head_valid && (head.id == op_id_reg)) begin
                    flag_next  = 1'b1;
                    push.id    = second.id;
                    push.delta = second.delta + head.delta;
                end else begin
                    push = head;
                end
            end else begin
                push = second;
            end
            if (pass_last) begin
                count_next              = count_reg - 1'b1;
                present_next[op_id_reg] = 1'b0;
            end
        end

        if (cmd.tick_dec) begin
            if (head.delta != '0) begin
                slot_next[0].delta = head.delta - 1'b1;
            end
        end

        if (cmd.tick_emit) begin
            shift                = 1'b1;
            count_next           = count_reg - 1'b1;
            present_next[head.id] = 1'b0;
            m_valid_next         = 1'b1;
            m_kind_next          = dltq_pkg::KIND_EXPIRY;
            m_id_next            = head.id;
            m_status_next        = dltq_pkg::ST_OK;
            m_last_next          = !((count_reg > dltq_pkg::count_t'(1)) &&
                                     (second.delta == '0));
        end

        if (cmd.ack_emit) begin
            m_valid_next  = 1'b1;
            m_kind_next   = dltq_pkg::KIND_ACK;
            m_id_next     = op_id_reg;
            m_status_next = cmd.ack_status;
            m_last_next   = 1'b1;
        end

        if (shift) begin
            for (int i = 0; i < N - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
            slot_next[N - 1] = push;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            present_reg <= '0;
            step_reg    <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            present_reg <= present_next;
            step_reg    <= step_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        op_id_reg    <= op_id_next;
        rem_reg      <= rem_next;
        carry_reg    <= carry_next;
        m_kind_reg   <= m_kind_next;
        m_id_reg     <= m_id_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_timer_id_res = m_id_reg;
    assign m_status       = m_status_reg;
    assign m_last         = m_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dltq_pkg::count_t'(N))
        else $error("entry count beyond slot count");

    a_bitmap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(present_reg) == int'(count_reg))
        else $error("occupancy bitmap disagrees with entry count");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ack_emit || cmd.tick_emit) |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transfer");
`endif

endmodule

[design/delta_list_timer_queue.sv]
// Top level of the delta-list timer queue: controller plus datapath.
// Depends on dltq_pkg, dltq_ctrl and dltq_datapath.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   s_opcode, s_timer_id, s_delay_ticks
//   m_       out        m_valid / m_ready   m_kind, m_timer_id_res, m_status, m_last
//
// Add or remove of a new timer: accept, a pass rotating the whole slot ring,
// then load the acknowledgement. Rejected add or remove: accept, then load the
// acknowledgement. Ignored opcode: accepted only. Tick: accept, decrement the
// head delta, then emit one expiry per expired head entry; empty queue: accept only.
// Synchronous reset clears the count and occupancy bitmap.
// A result held by m_ready low stalls the next result; s_ready stays low until that one is emitted.
module delta_list_timer_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dltq_pkg::OPCODE_BITS-1:0]    s_opcode,
    input  logic [dltq_pkg::ID_BITS-1:0]        s_timer_id,
    input  logic [dltq_pkg::IN_DELAY_BITS-1:0]  s_delay_ticks,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_kind,
    output logic [dltq_pkg::ID_BITS-1:0]        m_timer_id_res,
    output logic [dltq_pkg::STATUS_BITS-1:0]    m_status,
    output logic                                m_last
);

    dltq_pkg::dp_cmd_t  cmd;
    dltq_pkg::dp_stat_t st;

    dltq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .st       (st),
        .cmd      (cmd)
    );

    dltq_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_timer_id     (s_timer_id),
        .s_delay_ticks  (s_delay_ticks),
        .cmd            (cmd),
        .st             (st),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_timer_id_res (m_timer_id_res),
        .m_status       (m_status),
        .m_last         (m_last)
    );

endmodule
